[sv/multi_slot_interval_timer_table_assert.svh]
// Assertion macros shared by the timer table modules.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef MULTI_SLOT_INTERVAL_TIMER_TABLE_ASSERT_SVH
`define MULTI_SLOT_INTERVAL_TIMER_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MSTT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MSTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/mstt_pkg.sv]
package mstt_pkg;

  // Table size, clamped to what a 4-bit slot field can address
  localparam int SLOTS   = 16;
  localparam int TABLE_N = (SLOTS > 16) ? 16 : ((SLOTS < 1) ? 1 : SLOTS);
  localparam int SLOT_W  = 4;
  localparam int IDX_W   = (TABLE_N > 1) ? $clog2(TABLE_N) : 1;
  localparam int TIME_W  = 32;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_N - 1);

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_SET    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_FIRED = 2'd2,
    ST_DONE  = 2'd3
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic do_add;
    logic do_remove;
    logic do_set;
    logic scan_clear;
    logic scan_adv;
    logic out_fire;
    logic out_done;
  } mstt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    action_t action;
    logic    fired;
    logic    out_free;
    logic    scan_last;
  } mstt_stat_t;

endpackage

[sv/mstt_if.sv]
// Input item channel
interface mstt_in_if import mstt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [SLOT_W-1:0] slot;
  logic [TIME_W-1:0] interval;
  logic [TIME_W-1:0] now;

  modport source (output valid, action, slot, interval, now, input ready);
  modport sink   (input valid, action, slot, interval, now, output ready);
endinterface

// Result item channel
interface mstt_out_if import mstt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [SLOT_W-1:0] slot_out;
  logic [TIME_W-1:0] interval_out;
  logic              last;

  modport source (output valid, status, slot_out, interval_out, last, input ready);
  modport sink   (input valid, status, slot_out, interval_out, last, output ready);
endinterface

[sv/mstt_dp.sv]
`include "multi_slot_interval_timer_table_assert.svh"

module mstt_dp
  import mstt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_action,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic [TIME_W-1:0] in_interval,
  input  logic [TIME_W-1:0] in_now,
  input  mstt_cmd_t         cmd,
  output mstt_stat_t        stat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [SLOT_W-1:0] out_slot_out,
  output logic [TIME_W-1:0] out_interval_out,
  output logic              out_last
);

  // Item register
  action_t           item_action_r;
  logic [SLOT_W-1:0] item_slot_r;
  logic [TIME_W-1:0] item_interval_r;
  logic [TIME_W-1:0] item_now_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_action_r   <= action_t'(in_action);
      item_slot_r     <= in_slot;
      item_interval_r <= in_interval;
      item_now_r      <= in_now;
    end
  end

  logic             slot_ok;
  logic [IDX_W-1:0] item_idx;
  assign slot_ok  = (SLOT_W+1)'(item_slot_r) < (SLOT_W+1)'(TABLE_N);
  assign item_idx = item_slot_r[IDX_W-1:0];

  // Active bits and lowest free slot
  logic [TABLE_N-1:0] active_r;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_N - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  logic claim;
  assign claim = cmd.do_add && free_found;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else begin
      if (claim) active_r[free_idx] <= 1'b1;
      if (cmd.do_remove && slot_ok) active_r[item_idx] <= 1'b0;
    end
  end

  // Scan index; read address runs one ahead when advancing
  logic [IDX_W-1:0] scan_idx_r;
  logic [IDX_W-1:0] scan_idx_nxt;
  logic             scan_last;

  assign scan_last = (scan_idx_r == LAST_IDX);

  always_comb begin
    if (cmd.scan_clear)                  scan_idx_nxt = '0;
    else if (cmd.scan_adv && !scan_last) scan_idx_nxt = IDX_W'(scan_idx_r + 1'b1);
    else                                 scan_idx_nxt = scan_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) scan_idx_r <= '0;
    else        scan_idx_r <= scan_idx_nxt;
  end

  // Interval and start time memories, one write and one registered read each
  logic [TIME_W-1:0] ival_mem  [TABLE_N];
  logic [TIME_W-1:0] start_mem [TABLE_N];
  logic [TIME_W-1:0] ival_rd_r;
  logic [TIME_W-1:0] start_rd_r;

  logic             ival_we;
  logic [IDX_W-1:0] ival_waddr;
  logic             start_we;
  logic [IDX_W-1:0] start_waddr;

  assign ival_we     = claim || (cmd.do_set && slot_ok);
  assign ival_waddr  = cmd.do_add ? free_idx : item_idx;
  assign start_we    = claim || cmd.out_fire;
  assign start_waddr = cmd.do_add ? free_idx : scan_idx_r;

  always_ff @(posedge clk) begin
    if (ival_we) ival_mem[ival_waddr] <= item_interval_r;
    ival_rd_r <= ival_mem[scan_idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (start_we) start_mem[start_waddr] <= item_now_r;
    start_rd_r <= start_mem[scan_idx_nxt];
  end

  // Expiry check on the slot under the scan index
  logic [TIME_W-1:0] elapsed;
  logic              fired;
  assign elapsed = item_now_r - start_rd_r;
  assign fired   = active_r[scan_idx_r] && (elapsed >= ival_rd_r);

  // Output register
  logic              out_valid_r;
  status_t           out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [TIME_W-1:0] out_ival_r;
  logic              out_last_r;
  logic              out_free;
  logic              load_out;

  assign out_free = !out_valid_r || out_ready;
  assign load_out = cmd.do_add || cmd.out_fire || cmd.out_done;

  always_ff @(posedge clk) begin
    if (!rst_n)          out_valid_r <= 1'b0;
    else if (load_out)   out_valid_r <= 1'b1;
    else if (out_ready)  out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.do_add) begin
      out_status_r <= free_found ? ST_ADDED : ST_FULL;
      out_slot_r   <= free_found ? SLOT_W'(free_idx) : '0;
      out_ival_r   <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.out_fire) begin
      out_status_r <= ST_FIRED;
      out_slot_r   <= SLOT_W'(scan_idx_r);
      out_ival_r   <= ival_rd_r;
      out_last_r   <= 1'b0;
    end else if (cmd.out_done) begin
      out_status_r <= ST_DONE;
      out_slot_r   <= '0;
      out_ival_r   <= '0;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot_out     = out_slot_r;
  assign out_interval_out = out_ival_r;
  assign out_last         = out_last_r;

  assign stat.action    = item_action_r;
  assign stat.fired     = fired;
  assign stat.out_free  = out_free;
  assign stat.scan_last = scan_last;

  // Checks
  `MSTT_ASSERT_SAME(a_load_room, load_out, out_free, "result loaded over a pending beat")
  `MSTT_ASSERT_NEXT(a_fire_beat, cmd.out_fire, out_valid_r && out_status_r == ST_FIRED && !out_last_r, "fired beat not presented")
  `MSTT_ASSERT_NEXT(a_add_claim, claim, $countones(active_r) == $past($countones(active_r)) + 1, "add did not claim exactly one slot")

endmodule

[sv/mstt_ctrl.sv]
`include "multi_slot_interval_timer_table_assert.svh"

module mstt_ctrl
  import mstt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  mstt_stat_t stat,
  output mstt_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_PRIME = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.action)
          ACT_ADD: begin
            if (stat.out_free) begin
              cmd.do_add = 1'b1;
              state_nxt  = S_IDLE;
            end
          end
          ACT_REMOVE: begin
            cmd.do_remove = 1'b1;
            state_nxt     = S_IDLE;
          end
          ACT_SET: begin
            cmd.do_set = 1'b1;
            state_nxt  = S_IDLE;
          end
          ACT_TICK: begin
            cmd.scan_clear = 1'b1;
            state_nxt      = S_PRIME;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      // first slot's entries are read here
      S_PRIME: state_nxt = S_SCAN;
      S_SCAN: begin
        if (!stat.fired || stat.out_free) begin
          cmd.scan_adv = 1'b1;
          cmd.out_fire = stat.fired;
          if (stat.scan_last) state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_done = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Checks
  `MSTT_ASSERT_NEXT(a_accept_exec, state_r == S_IDLE && in_valid, state_r == S_EXEC, "accepted item not executed")
  `MSTT_ASSERT_NEXT(a_scan_done, state_r == S_SCAN && cmd.scan_adv && stat.scan_last, state_r == S_DONE, "scan end missed")
  `MSTT_ASSERT_SAME(a_fire_room, cmd.out_fire, stat.out_free, "fired beat issued without room")

endmodule

[sv/multi_slot_interval_timer_table.sv]
// Interval timer table, one item at a time.
// Remove and set_interval: accepted in S_IDLE, executed in S_EXEC, then back to S_IDLE.
// Add: the result beat is loaded from S_EXEC, after any wait for the output register.
// Tick: one cycle per slot in a scan with a single memory read port, while no
//   fired slot waits for the output register, then ends with the done beat.
// Reset (synchronous, rst_n low) clears all active bits; no clearing pass.
module multi_slot_interval_timer_table
  import mstt_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  mstt_in_if.sink     in_ch,
  mstt_out_if.source  out_ch
);

  mstt_cmd_t  cmd;
  mstt_stat_t stat;

  mstt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mstt_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_action        (in_ch.action),
    .in_slot          (in_ch.slot),
    .in_interval      (in_ch.interval),
    .in_now           (in_ch.now),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.status),
    .out_slot_out     (out_ch.slot_out),
    .out_interval_out (out_ch.interval_out),
    .out_last         (out_ch.last)
  );

endmodule

[test/mstt_event_checker.sv]
`timescale 1ns / 100ps

module mstt_event_checker
  import mstt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  mstt_in_if   in_ch,
  mstt_out_if  out_ch,
  output int   errors,
  output int   pending,
  output int   fired_beats,
  output int   full_beats
);

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] interval;
    logic              last;
  } timer_event_t;

  // Shadow copy of the timer table
  logic              armed   [TABLE_N];
  logic [TIME_W-1:0] period  [TABLE_N];
  logic [TIME_W-1:0] started [TABLE_N];

  timer_event_t due_events[$];
  timer_event_t want;
  int           mismatches;
  int           fires;
  int           fulls;

  task automatic push_event(input status_t st, input int unsigned idx,
                            input logic [TIME_W-1:0] iv, input logic lst);
    timer_event_t ev;
    ev.status   = st;
    ev.slot     = SLOT_W'(idx);
    ev.interval = iv;
    ev.last     = lst;
    due_events.push_back(ev);
  endtask

  // Work out the result beats one input beat causes, and update the table
  task automatic predict_events(input action_t act, input logic [SLOT_W-1:0] slot,
                                input logic [TIME_W-1:0] iv,
                                input logic [TIME_W-1:0] now);
    bit                claimed;
    logic [TIME_W-1:0] elapsed;
    claimed = 1'b0;
    case (act)
      ACT_ADD: begin
        // lowest free slot wins
        for (int k = 0; k < TABLE_N; k++) begin
          if (!claimed && !armed[k]) begin
            claimed    = 1'b1;
            armed[k]   = 1'b1;
            period[k]  = iv;
            started[k] = now;
            push_event(ST_ADDED, k, '0, 1'b1);
          end
        end
        if (!claimed) push_event(ST_FULL, 0, '0, 1'b1);
      end
      ACT_REMOVE: begin
        if (slot < TABLE_N) armed[slot] = 1'b0;
      end
      ACT_TICK: begin
        // elapsed time wraps modulo 2^32
        for (int k = 0; k < TABLE_N; k++) begin
          elapsed = now - started[k];
          if (armed[k] && elapsed >= period[k]) begin
            push_event(ST_FIRED, k, period[k], 1'b0);
            started[k] = now;
          end
        end
        push_event(ST_DONE, 0, '0, 1'b1);
      end
      default: begin
        if (slot < TABLE_N) period[slot] = iv;
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TABLE_N; k++) armed[k] = 1'b0;
      due_events.delete();
      mismatches = 0;
      fires      = 0;
      fulls      = 0;
    end else begin
      // result side first: a beat leaving now belongs to an earlier input
      if (out_ch.valid && out_ch.ready) begin
        if (due_events.size() == 0) begin
          $error("unexpected result beat: status %0d slot %0d interval %0d last %0d",
                 out_ch.status, out_ch.slot_out, out_ch.interval_out, out_ch.last);
          mismatches++;
        end else begin
          want = due_events.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            mismatches++;
          end
          if (out_ch.slot_out !== want.slot) begin
            $error("slot_out: expected %0d, got %0d", want.slot, out_ch.slot_out);
            mismatches++;
          end
          if (out_ch.interval_out !== want.interval) begin
            $error("interval_out: expected 0x%08h, got 0x%08h",
                   want.interval, out_ch.interval_out);
            mismatches++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_ch.last);
            mismatches++;
          end
          if (want.status == ST_FIRED) fires++;
          if (want.status == ST_FULL) fulls++;
        end
      end
      if (in_ch.valid && in_ch.ready)
        predict_events(action_t'(in_ch.action), in_ch.slot, in_ch.interval, in_ch.now);
    end
    errors      <= mismatches;
    pending     <= due_events.size();
    fired_beats <= fires;
    full_beats  <= fulls;
  end

endmodule

[test/multi_slot_interval_timer_table_tb.sv]
`timescale 1ns / 100ps

module multi_slot_interval_timer_table_tb
  import mstt_pkg::*;
();

  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 40;

  logic clk;
  logic rst_n;

  mstt_in_if  in_ch();
  mstt_out_if out_ch();

  int errors;
  int pending;
  int fired_beats;
  int full_beats;

  bit                in_idle_on;
  bit                out_idle_on;
  logic [TIME_W-1:0] wall;
  int                n_add;
  int                n_remove;
  int                n_tick;
  int                n_set;
  int                stalled;

  multi_slot_interval_timer_table u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mstt_event_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .errors      (errors),
    .pending     (pending),
    .fired_beats (fired_beats),
    .full_beats  (full_beats)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_idle_on) begin
      out_ch.ready <= ($urandom_range(0, 99) >= 28);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // One input beat; valid stays high after acceptance until the next call
  task automatic send(input action_t act, input logic [SLOT_W-1:0] slot,
                      input logic [TIME_W-1:0] iv, input logic [TIME_W-1:0] now);
    while (in_idle_on && $urandom_range(0, 99) < 28) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.slot     <= slot;
    in_ch.interval <= iv;
    in_ch.now      <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    case (act)
      ACT_ADD:    n_add++;
      ACT_REMOVE: n_remove++;
      ACT_TICK:   n_tick++;
      default:    n_set++;
    endcase
  endtask

  // Hold off the sender until every predicted result beat has come back
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Random beat; time mostly moves forward in small steps so timers expire
  task automatic random_item(input int unsigned add_w, input int unsigned rem_w,
                             input int unsigned tick_w);
    int unsigned       roll;
    logic [TIME_W-1:0] iv;
    logic [TIME_W-1:0] t;
    roll = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0:       iv = '0;
      1:       iv = $urandom();
      default: iv = $urandom_range(1, 60);
    endcase
    t = ($urandom_range(0, 19) == 0) ? TIME_W'($urandom()) : wall;
    if (roll < add_w) begin
      send(ACT_ADD, SLOT_W'($urandom_range(0, 15)), iv, t);
    end else if (roll < add_w + rem_w) begin
      send(ACT_REMOVE, SLOT_W'($urandom_range(0, 15)), iv, t);
    end else if (roll < add_w + rem_w + tick_w) begin
      if ($urandom_range(0, 19) == 0) wall = $urandom();
      else wall = wall + $urandom_range(0, 24);
      send(ACT_TICK, SLOT_W'($urandom_range(0, 15)), iv, wall);
    end else begin
      send(ACT_SET, SLOT_W'($urandom_range(0, 15)), iv, t);
    end
  endtask

  // Watchdog: too long without any beat on either channel
  initial begin
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("multi_slot_interval_timer_table_tb: FAIL");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.action   = ACT_ADD;
    in_ch.slot     = '0;
    in_ch.interval = '0;
    in_ch.now      = '0;
    in_idle_on     = 1'b1;
    out_idle_on    = 1'b1;
    wall           = 32'hFFFF_FE00;
    n_add          = 0;
    n_remove       = 0;
    n_tick         = 0;
    n_set          = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty tick, extreme values, wrap, full table
    send(ACT_TICK, 4'd0, '0, '0);
    send(ACT_ADD, 4'd0, '0, '0);
    send(ACT_ADD, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(ACT_ADD, 4'd0, 32'd5, 32'hFFFF_FFFE);
    // zero interval fires; the wrapped start fires with an elapsed time of exactly 5
    send(ACT_TICK, 4'd0, '0, 32'd3);
    send(ACT_SET, 4'd15, 32'd7, '0);
    send(ACT_SET, 4'd2, 32'hAAAA_5555, '0);
    send(ACT_REMOVE, 4'd1, '0, '0);
    send(ACT_REMOVE, 4'd1, '0, '0);
    for (int k = 0; k < 14; k++) send(ACT_ADD, 4'd0, 32'(k * 3), 32'(k));
    send(ACT_ADD, 4'd0, 32'd1, '0);
    send(ACT_TICK, 4'd0, '0, 32'hFFFF_FFFF);
    wait_for_results();

    // Random, both sides idling, add, remove and tick weighted equally
    for (int k = 0; k < 180; k++) random_item(30, 30, 30);
    wait_for_results();

    // Random, no idling at all, add-heavy
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    for (int k = 0; k < 120; k++) random_item(40, 15, 35);
    wait_for_results();

    // Random, idling again
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    for (int k = 0; k < 150; k++) random_item(25, 35, 30);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d adds (%0d refused on a full table), %0d removes, %0d interval writes,",
             n_add, full_beats, n_remove, n_set);
    $display("and %0d ticks that fired %0d timers, with random stalls on both channels.",
             n_tick, fired_beats);
    if (errors == 0 && pending == 0) begin
      $display("multi_slot_interval_timer_table_tb: PASS");
    end else begin
      $display("multi_slot_interval_timer_table_tb: FAIL");
    end
    $finish;
  end

endmodule
